[rtl/core/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg: shared definitions for the accelerometer stability detector
// Widths, window geometry, reciprocal constants, register indexes and the
// beat structs that travel between the pipeline modules.
// ----------------------------------------------------------------------------
package asc_pkg;

	// Window length in samples
	localparam int WINDOW     = 10;
	localparam int CHAIN_LEN  = WINDOW - 1;
	localparam int FILL_W     = $clog2(WINDOW);

	// Sample and motion widths
	localparam int AXIS_W     = 16;
	localparam int MAG_W      = 15;
	localparam int MOTION_W   = 17;
	localparam int MOTION_MAX = 3 * 32767;
	localparam int AVG_W      = 17;

	// Running sum holds up to WINDOW motion values
	localparam int SUM_W      = $clog2(MOTION_MAX * WINDOW + 1);

	// Divide by WINDOW as multiply by ceil(2^k / WINDOW), exact for sums below 2^SUM_W
	localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
	localparam int RECIP_W     = SUM_W + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	// Configuration registers
	localparam int THR_W      = 17;
	localparam int INTV_W     = 16;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_STABLE_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL  = CFG_IDX_W'(1);

	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(2000);
	localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(100);
	localparam logic [INTV_W-1:0] QUIET_MAX  = '1;

	// Report causes
	localparam logic CAUSE_CHANGE   = 1'b0;
	localparam logic CAUSE_PERIODIC = 1'b1;

	// Motion beat from the front end into the window chain
	typedef struct packed {
		logic                valid;
		logic [MOTION_W-1:0] motion;
	} motion_beat_t;

	// Scaled window sum into the decision stage
	typedef struct packed {
		logic              valid;
		logic              full;
		logic [PROD_W-1:0] product;
	} window_beat_t;

endpackage

[rtl/core/asc_sample_if.sv]
// ----------------------------------------------------------------------------
// asc_sample_if: accelerometer sample channel
// Valid/ready channel carrying one three-axis sample per beat.
// ----------------------------------------------------------------------------
interface asc_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		output ready);
endinterface

[rtl/core/asc_report_if.sv]
// ----------------------------------------------------------------------------
// asc_report_if: stability report channel
// Valid/ready channel carrying one stability report per beat.
// ----------------------------------------------------------------------------
interface asc_report_if;
	logic        valid;
	logic        ready;
	logic        report_stable;
	logic        report_cause;
	logic [16:0] window_average;

	modport source (output valid, output report_stable, output report_cause,
		output window_average, input ready);
	modport sink (input valid, input report_stable, input report_cause,
		input window_average, output ready);
endinterface

[rtl/core/asc_motion.sv]
// ----------------------------------------------------------------------------
// asc_motion: per-axis motion front end
// Differences each axis against its previous sample, takes the saturated
// magnitude and sums the three axes into one motion value.
// ----------------------------------------------------------------------------
module asc_motion
	import asc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic                     take,
	input  logic signed [AXIS_W-1:0] accel_x,
	input  logic signed [AXIS_W-1:0] accel_y,
	input  logic signed [AXIS_W-1:0] accel_z,
	output motion_beat_t             beat_s1
);

	logic [AXIS_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [MAG_W-1:0]  mag_x, mag_y, mag_z;
	logic              valid_s1;
	logic [MOTION_W-1:0] motion_s1;

	function automatic logic [MAG_W-1:0] axis_mag(input logic [AXIS_W-1:0] cur,
		input logic [AXIS_W-1:0] prev);
		logic [AXIS_W-1:0] d;
		logic [AXIS_W-1:0] neg;
		d   = cur - prev;
		neg = ~d + AXIS_W'(1);
		if (!d[AXIS_W-1])
			return d[MAG_W-1:0];
		else if (neg[AXIS_W-1])
			return '1;
		else
			return neg[MAG_W-1:0];
	endfunction

	assign mag_x = axis_mag(accel_x, prev_x_q);
	assign mag_y = axis_mag(accel_y, prev_y_q);
	assign mag_z = axis_mag(accel_z, prev_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= take;
			if (take) begin
				prev_x_q <= accel_x;
				prev_y_q <= accel_y;
				prev_z_q <= accel_z;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take) begin
			motion_s1 <= MOTION_W'(mag_x) + MOTION_W'(mag_y) + MOTION_W'(mag_z);
		end
	end

	assign beat_s1.valid  = valid_s1;
	assign beat_s1.motion = motion_s1;

endmodule

[rtl/core/asc_cell.sv]
// ----------------------------------------------------------------------------
// asc_cell: one window cell
// Holds one motion value and hands it to the next cell on each push.
// ----------------------------------------------------------------------------
module asc_cell
	import asc_pkg::*;
(
	input  logic                clk,
	input  logic                push,
	input  logic [MOTION_W-1:0] d_in,
	output logic [MOTION_W-1:0] d_out
);

	logic [MOTION_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (push) begin
			value_q <= d_in;
		end
	end

	assign d_out = value_q;

endmodule

[rtl/core/asc_window.sv]
// ----------------------------------------------------------------------------
// asc_window: sliding window of motion values
// Pushes each motion value into a chain of cells, keeps the running sum of
// the last WINDOW-1 values and scales the full window sum by 1/WINDOW.
// ----------------------------------------------------------------------------
module asc_window
	import asc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  motion_beat_t beat_s1,
	output window_beat_t beat_s3
);

	logic [MOTION_W-1:0] tap [CHAIN_LEN];
	logic                push;
	logic                full;
	logic [FILL_W-1:0]   fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    total;
	logic [SUM_W-1:0]    total_s2;
	logic                full_s2, valid_s2;
	logic [PROD_W-1:0]   product_s3;
	logic                full_s3, valid_s3;

	assign push  = advance && beat_s1.valid;
	assign full  = (fill_q == FILL_W'(WINDOW - 1));
	assign total = sum_q + SUM_W'(beat_s1.motion);

	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain
		if (i == 0) begin : g_head
			asc_cell u_cell (
				.clk   (clk),
				.push  (push),
				.d_in  (beat_s1.motion),
				.d_out (tap[i])
			);
		end else begin : g_body
			asc_cell u_cell (
				.clk   (clk),
				.push  (push),
				.d_in  (tap[i-1]),
				.d_out (tap[i])
			);
		end
	end

	// Drop the oldest value once the window is full, so WINDOW-1 stay summed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			sum_q    <= '0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= beat_s1.valid;
			valid_s3 <= valid_s2;
			if (beat_s1.valid) begin
				if (full)
					sum_q <= total - SUM_W'(tap[CHAIN_LEN-1]);
				else begin
					sum_q  <= total;
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (beat_s1.valid) begin
				total_s2 <= total;
				full_s2  <= full;
			end
			if (valid_s2) begin
				product_s3 <= PROD_W'(total_s2) * PROD_W'(RECIP);
				full_s3    <= full_s2;
			end
		end
	end

	assign beat_s3.valid   = valid_s3;
	assign beat_s3.full    = full_s3;
	assign beat_s3.product = product_s3;

endmodule

[rtl/core/accel_stability_detector.sv]
// ----------------------------------------------------------------------------
// accel_stability_detector: windowed motion stability detector
// Turns a three-axis accelerometer stream into stable/moving reports.
// ----------------------------------------------------------------------------
// One sample beat is taken per clock cycle unless a report waits on the sink.
// Each beat's axis differences are summed into a motion value (s1), pushed
// through a chain of WINDOW-1 cells that keeps a running sum (s2), scaled by
// 1/WINDOW with a reciprocal multiply (s3) and judged against
// stable_threshold (s4), whose result sits in the output register. Until WINDOW
// samples have arrived the average holds at its last value (0 after reset).
// A report beat is issued when the stable state flips, or as a periodic
// repeat once more than report_interval quiet samples have passed; most
// samples give no report. The report sits in an output register; while it
// waits on the sink the whole pipeline holds and no new sample is taken.
// Write configuration only while no sample is in flight.
// ----------------------------------------------------------------------------
module accel_stability_detector
	import asc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	asc_sample_if.sink            samples,
	asc_report_if.source          reports,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic              advance;
	logic              take;
	motion_beat_t      motion_s1;
	window_beat_t      window_s3;

	logic [THR_W-1:0]  thr_q;
	logic [INTV_W-1:0] intv_q;

	logic [AVG_W-1:0]  held_avg_q;
	logic              stable_q;
	logic [INTV_W-1:0] quiet_q;

	logic [AVG_W-1:0]  avg;
	logic              now_stable;
	logic              changed;
	logic              periodic;

	logic              out_valid_q;
	logic              out_stable_q;
	logic              out_cause_q;
	logic [AVG_W-1:0]  out_avg_q;

	// Advance the whole pipe unless a report is stuck in the output register
	assign advance       = !out_valid_q || reports.ready;
	assign samples.ready = advance;
	assign take          = samples.valid && advance;

	asc_motion u_motion (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.take    (take),
		.accel_x (samples.accel_x),
		.accel_y (samples.accel_y),
		.accel_z (samples.accel_z),
		.beat_s1 (motion_s1)
	);

	asc_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat_s1 (motion_s1),
		.beat_s3 (window_s3)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			intv_q <= INTV_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STABLE_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				REG_REPORT_INTERVAL:  intv_q <= cfg_data[INTV_W-1:0];
				default: ;
			endcase
		end
	end

	// Decision stage: refresh the average only once the window is full
	assign avg        = window_s3.full ? AVG_W'(window_s3.product >> RECIP_SHIFT)
	                                   : held_avg_q;
	assign now_stable = (avg < thr_q);
	assign changed    = (now_stable != stable_q);
	assign periodic   = (quiet_q > intv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_avg_q  <= '0;
			stable_q    <= 1'b0;
			quiet_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= window_s3.valid && (changed || periodic);
			if (window_s3.valid) begin
				held_avg_q <= avg;
				if (changed) begin
					stable_q <= now_stable;
					quiet_q  <= '0;
				end else if (periodic) begin
					quiet_q <= '0;
				end else if (quiet_q != QUIET_MAX) begin
					quiet_q <= quiet_q + INTV_W'(1);
				end
			end
		end
	end

	// Report payload; hold while the sink stalls
	always_ff @(posedge clk) begin
		if (advance && window_s3.valid) begin
			out_stable_q <= now_stable;
			out_cause_q  <= changed ? CAUSE_CHANGE : CAUSE_PERIODIC;
			out_avg_q    <= avg;
		end
	end

	assign reports.valid          = out_valid_q;
	assign reports.report_stable  = out_stable_q;
	assign reports.report_cause   = out_cause_q;
	assign reports.window_average = out_avg_q;

endmodule

[test/accel_stability_detector_test.sv]
// ----------------------------------------------------------------------------
// accel_stability_detector_test: self-checking bench for the stability detector
// Streams three-axis samples into the detector under random idling on both
// channels, predicts the stable/moving reports from the accepted beats and
// checks every report beat field by field against the predicted order.
// ----------------------------------------------------------------------------
module accel_stability_detector_test;
	import asc_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int CYCLE_LIMIT   = 1_000_000;
	// Pipeline is 4 deep; give a silent sample in flight ample time to land
	localparam int DRAIN_CYCLES  = 12;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_SAMPLES = 190;
	localparam int MOVING_RUN    = 150;
	// Back to back run under the widest interval
	localparam int QUIET_RUN     = 150;
	localparam int DIR_N         = 25;
	localparam logic [CFG_DATA_W-1:0] THR_TOP  = CFG_DATA_W'(131071);
	localparam logic [CFG_DATA_W-1:0] INTV_TOP = CFG_DATA_W'(65534);

	typedef struct packed {
		logic             stable;
		logic             cause;
		logic [AVG_W-1:0] average;
	} report_t;

	// Directed stimulus row; typed rows carry a hand-read expectation
	typedef struct packed {
		logic [AXIS_W-1:0] x;
		logic [AXIS_W-1:0] y;
		logic [AXIS_W-1:0] z;
		logic              typed;
		logic              fires;
		report_t           rep;
	} sample_row_t;

	typedef enum logic [1:0] {GEN_STILL, GEN_SHAKE, GEN_EXTREME} motion_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_STABLE_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	asc_sample_if samples_ch ();
	asc_report_if reports_ch ();

	accel_stability_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.reports  (reports_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Directed rows. Rows 0..9 are typed: the first sample against an
	// all-zero history flips the detector to stable with average 0, the
	// next eight alternate between 0 and the most negative value (every
	// axis difference is exactly -32768 or +32768 wrapped, i.e. magnitude
	// 32767) while the window is still filling, so the held average stays
	// 0 and nothing is reported. The tenth sample fills the window: nine
	// motions of 98301 plus one of 0 give 884709 / 10 = 88470, moving.
	// The rest walk the opposite extremes and then settle to a small
	// jitter, so the window flushes and the detector returns to stable.
	// ------------------------------------------------------------------
	sample_row_t directed_rows [DIR_N] = '{
		'{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '{1'b1, CAUSE_CHANGE, 17'd0}},
		'{16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '{1'b0, CAUSE_CHANGE, 17'd0}},
		'{16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1, '{1'b0, CAUSE_CHANGE, 17'd88470}},
		'{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0},
		'{16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, '0},
		'{16'h7FFF, 16'h8000, 16'h0000, 1'b0, 1'b0, '0},
		'{16'h0064, 16'hFF38, 16'h4000, 1'b0, 1'b0, '0},
		'{16'h0065, 16'hFF39, 16'h4001, 1'b0, 1'b0, '0},
		'{16'h0064, 16'hFF38, 16'h4000, 1'b0, 1'b0, '0},
		'{16'h0065, 16'hFF39, 16'h4001, 1'b0, 1'b0, '0},
		'{16'h0064, 16'hFF38, 16'h4000, 1'b0, 1'b0, '0},
		'{16'h0065, 16'hFF39, 16'h4001, 1'b0, 1'b0, '0},
		'{16'h0064, 16'hFF38, 16'h4000, 1'b0, 1'b0, '0},
		'{16'h0065, 16'hFF39, 16'h4001, 1'b0, 1'b0, '0},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
		'{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0}
	};

	// Reports still owed by the detector, oldest first
	report_t pending_reports [$];
	report_t report_want;

	int  cycle_count    = 0;
	int  samples_sent   = 0;
	int  reports_seen   = 0;
	int  mismatch_count = 0;
	int  reg_writes     = 0;
	logic send_gaps     = 1'b1;
	logic recv_stalls   = 1'b1;

	// Detector state as the predictor tracks it
	logic [AXIS_W-1:0]   last_x, last_y, last_z;
	logic [MOTION_W-1:0] motion_ring [WINDOW];
	int unsigned         ring_sum, ring_fill, ring_pos;
	logic [AVG_W-1:0]    avg_held;
	logic                flag_stable;
	int unsigned         quiet_run;
	logic [THR_W-1:0]    thr_reg;
	logic [INTV_W-1:0]   intv_reg;

	// Random sample shaping
	motion_mode_t      gen_mode = GEN_STILL;
	int                gen_left = 0;
	int                gen_amp  = 0;
	logic [AXIS_W-1:0] gen_base_x = '0, gen_base_y = '0, gen_base_z = '0;

	// Magnitude of one axis step, wrapped to 16 bits; the most negative
	// step saturates to 32767
	function automatic logic [MOTION_W-1:0] axis_swing(input logic [AXIS_W-1:0] cur,
		input logic [AXIS_W-1:0] prev);
		logic [AXIS_W-1:0] d;
		logic [AXIS_W-1:0] neg;
		d   = cur - prev;
		neg = ~d + 1'b1;
		if (d == 16'h8000)
			return MOTION_W'(32767);
		if (d[AXIS_W-1])
			return MOTION_W'(neg);
		return MOTION_W'(d);
	endfunction

	// Advance the tracked detector by one accepted sample; fires tells
	// whether the sample owes a report
	task automatic predict_report(input logic [AXIS_W-1:0] x, y, z,
		output logic fires, output report_t rep);
		logic [MOTION_W-1:0] motion;
		logic                now_stable;
		motion = axis_swing(x, last_x) + axis_swing(y, last_y) + axis_swing(z, last_z);
		last_x = x;
		last_y = y;
		last_z = z;
		motion_ring[ring_pos] = motion;
		ring_sum += motion;
		if (ring_fill + 1 >= WINDOW) begin
			avg_held = AVG_W'(ring_sum / WINDOW);
			ring_sum -= motion_ring[(ring_pos + 1) % WINDOW];
		end else begin
			ring_fill++;
		end
		ring_pos = (ring_pos + 1) % WINDOW;
		now_stable = avg_held < thr_reg;
		fires = 1'b0;
		rep   = '{flag_stable, CAUSE_CHANGE, avg_held};
		if (now_stable != flag_stable) begin
			flag_stable = now_stable;
			quiet_run   = 0;
			fires       = 1'b1;
			rep         = '{now_stable, CAUSE_CHANGE, avg_held};
		end else if (quiet_run > intv_reg) begin
			quiet_run = 0;
			fires     = 1'b1;
			rep       = '{flag_stable, CAUSE_PERIODIC, avg_held};
		end else if (quiet_run < QUIET_MAX) begin
			quiet_run++;
		end
	endtask

	// Drive one sample beat; called right after a rising edge and returns
	// right after the edge that accepted it, with valid still high
	task automatic send_sample(input logic [AXIS_W-1:0] x, y, z,
		output logic fires, output report_t rep);
		int gap;
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			samples_ch.valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid   <= 1'b1;
		samples_ch.accel_x <= x;
		samples_ch.accel_y <= y;
		samples_ch.accel_z <= z;
		// Ready is settled by the falling edge; the beat moves on the next rise
		do @(negedge clk); while (!samples_ch.ready);
		predict_report(x, y, z, fires, rep);
		@(posedge clk);
		samples_sent++;
	endtask

	// Write one register once the detector has gone quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STABLE_THRESHOLD)
			thr_reg = THR_W'(value);
		else
			intv_reg = INTV_W'(value);
		reg_writes++;
	endtask

	function automatic logic [AXIS_W-1:0] jitter_around(input logic [AXIS_W-1:0] base,
		input int amp);
		int j;
		j = int'($urandom_range(0, 2 * amp)) - amp;
		return base + AXIS_W'(j);
	endfunction

	function automatic logic [AXIS_W-1:0] extreme_value();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Mostly rest stretches with small jitter around a held pose, broken
	// by bursts of shaking and of rail-to-rail swings, so the window
	// average crosses thresholds in both directions
	task automatic next_motion_sample(output logic [AXIS_W-1:0] x, y, z);
		int pick;
		if (gen_left == 0) begin
			pick     = $urandom_range(0, 9);
			gen_mode = (pick < 6) ? GEN_STILL : (pick < 9) ? GEN_SHAKE : GEN_EXTREME;
			gen_left = (gen_mode == GEN_STILL) ? $urandom_range(1, 40) : $urandom_range(1, 12);
			case ($urandom_range(0, 4))
				0: gen_amp = 0;
				1: gen_amp = 1;
				2: gen_amp = 8;
				3: gen_amp = 64;
				default: gen_amp = 600;
			endcase
			if ($urandom_range(0, 2) == 0) begin
				gen_base_x = AXIS_W'($urandom);
				gen_base_y = AXIS_W'($urandom);
				gen_base_z = AXIS_W'($urandom);
			end
		end
		gen_left--;
		case (gen_mode)
			GEN_STILL: begin
				x = jitter_around(gen_base_x, gen_amp);
				y = jitter_around(gen_base_y, gen_amp);
				z = jitter_around(gen_base_z, gen_amp);
			end
			GEN_SHAKE: begin
				x = AXIS_W'($urandom);
				y = AXIS_W'($urandom);
				z = AXIS_W'($urandom);
			end
			default: begin
				x = extreme_value();
				y = extreme_value();
				z = extreme_value();
			end
		endcase
	endtask

	task automatic run_phase(input int count);
		logic [AXIS_W-1:0] x, y, z;
		logic              fires;
		report_t           rep;
		for (int i = 0; i < count; i++) begin
			next_motion_sample(x, y, z);
			send_sample(x, y, z, fires, rep);
			if (fires)
				pending_reports.push_back(rep);
		end
		samples_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Report sink: drop ready in random bursts while stalls are enabled
	// ------------------------------------------------------------------
	initial begin
		int hold;
		hold = 0;
		reports_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				reports_ch.ready <= 1'b0;
			end else if (recv_stalls && $urandom_range(0, 6) == 0) begin
				hold = $urandom_range(1, 18) - 1;
				reports_ch.ready <= 1'b0;
			end else begin
				reports_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Report checker: sample the handshake at the falling edge, where
	// every signal has settled, and match against the oldest expectation
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && reports_ch.valid && reports_ch.ready) begin
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				$display("%0t: report beat with none expected: stable %0b cause %0b average %0d",
					$time, reports_ch.report_stable, reports_ch.report_cause,
					reports_ch.window_average);
			end else begin
				report_want = pending_reports.pop_front();
				reports_seen++;
				if (reports_ch.report_stable !== report_want.stable) begin
					mismatch_count++;
					$display("%0t: report_stable expected %0b actual %0b", $time,
						report_want.stable, reports_ch.report_stable);
				end
				if (reports_ch.report_cause !== report_want.cause) begin
					mismatch_count++;
					$display("%0t: report_cause expected %0b actual %0b", $time,
						report_want.cause, reports_ch.report_cause);
				end
				if (reports_ch.window_average !== report_want.average) begin
					mismatch_count++;
					$display("%0t: window_average expected %0d actual %0d", $time,
						report_want.average, reports_ch.window_average);
				end
			end
		end
	end

	// Hard stop for a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reports outstanding", $time,
				pending_reports.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic                  fires;
		report_t               rep;
		logic [CFG_DATA_W-1:0] thr_pick;
		logic [CFG_DATA_W-1:0] intv_pick;
		logic                  closing;

		// Hold every input at a known value from time zero
		samples_ch.valid   = 1'b0;
		samples_ch.accel_x = '0;
		samples_ch.accel_y = '0;
		samples_ch.accel_z = '0;

		// Tracked state starts from the reset values
		last_x      = '0;
		last_y      = '0;
		last_z      = '0;
		ring_sum    = 0;
		ring_fill   = 0;
		ring_pos    = 0;
		avg_held    = '0;
		flag_stable = 1'b0;
		quiet_run   = 0;
		thr_reg     = THR_RESET;
		intv_reg    = INTV_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset settings
		foreach (directed_rows[i]) begin
			send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
				fires, rep);
			if (directed_rows[i].typed) begin
				if (directed_rows[i].fires)
					pending_reports.push_back(directed_rows[i].rep);
			end else if (fires) begin
				pending_reports.push_back(rep);
			end
		end
		samples_ch.valid <= 1'b0;

		// Threshold 0 never counts as stable; interval 0 repeats every
		// other sample
		write_reg(REG_STABLE_THRESHOLD, '0);
		write_reg(REG_REPORT_INTERVAL, '0);
		run_phase(MOVING_RUN);

		// Top threshold keeps every average stable; the widest interval
		// holds off repeats, back to back beats
		write_reg(REG_STABLE_THRESHOLD, THR_TOP);
		write_reg(REG_REPORT_INTERVAL, INTV_TOP);
		send_gaps = 1'b0;
		run_phase(QUIET_RUN);

		// Random settings; the closing phase runs with no idling at all
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: thr_pick = '0;
				1: thr_pick = THR_TOP;
				2, 3: thr_pick = CFG_DATA_W'($urandom_range(0, 4000));
				4: thr_pick = CFG_DATA_W'($urandom_range(0, 70000));
				default: thr_pick = CFG_DATA_W'($urandom_range(0, 131071));
			endcase
			case ($urandom_range(0, 3))
				0: intv_pick = '0;
				1, 2: intv_pick = CFG_DATA_W'($urandom_range(1, 30));
				default: intv_pick = CFG_DATA_W'($urandom_range(0, 65534));
			endcase
			write_reg(REG_STABLE_THRESHOLD, thr_pick);
			write_reg(REG_REPORT_INTERVAL, intv_pick);
			closing     = (p == RANDOM_PHASES - 1);
			send_gaps   = !closing && ($urandom_range(0, 3) != 0);
			recv_stalls = !closing && ($urandom_range(0, 3) != 0);
			run_phase(PHASE_SAMPLES);
		end

		// Let the last reports land, then allow for stray beats
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d sample beats across %0d register writes, checked %0d reports.",
			samples_sent, reg_writes, reports_seen);
		$display("Thresholds and intervals ran from 0 to their top values; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0 && pending_reports.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/asc_pkg.sv
rtl/core/asc_sample_if.sv
rtl/core/asc_report_if.sv
rtl/core/asc_motion.sv
rtl/core/asc_cell.sv
rtl/core/asc_window.sv
rtl/core/accel_stability_detector.sv
test/accel_stability_detector_test.sv
